// File: hw/rtl/qrto_pkg.sv
// Shared types and constants for the quaternion tool offset pipeline.
`default_nettype none

package qrto_pkg;

    localparam int unsigned CFG_INDEX_W  = 2;
    localparam int unsigned PIPE_LATENCY = 6;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_OFFSET_X = 2'd0,
        REG_OFFSET_Y = 2'd1,
        REG_OFFSET_Z = 2'd2
    } reg_index_t;

    localparam logic signed [31:0] Q16_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q16_MIN = 32'sh8000_0000;

    // Unit quaternion components, Q1.15.
    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic signed [15:0] w;
    } quat_t;

    // Q16.16 vector.
    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } vec32_t;

    // Offset plus position, one bit of growth.
    typedef struct packed {
        logic signed [32:0] x;
        logic signed [32:0] y;
        logic signed [32:0] z;
    } vec33_t;

    // Exact cross product of q.xyz and the offset, units of 2^-31.
    typedef struct packed {
        logic signed [48:0] x;
        logic signed [48:0] y;
        logic signed [48:0] z;
    } vec49_t;

    // Exact sums in units of 2^-43, rounding bias already added.
    typedef struct packed {
        logic signed [65:0] x;
        logic signed [65:0] y;
        logic signed [65:0] z;
    } acc_t;

endpackage

`default_nettype wire

// File: hw/rtl/qrto_cross.sv
// Two pipeline stages: q.xyz times offset products and the base sum, then the cross product.
`default_nettype none

module qrto_cross (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    input  wire qrto_pkg::quat_t  q,
    input  wire qrto_pkg::vec32_t pos,
    input  wire qrto_pkg::vec32_t offset,
    output logic                 out_valid,
    output qrto_pkg::quat_t      q_out,
    output qrto_pkg::vec33_t     base_out,
    output qrto_pkg::vec49_t     tp_out
);

    typedef struct packed {
        logic signed [47:0] yz;
        logic signed [47:0] zy;
        logic signed [47:0] zx;
        logic signed [47:0] xz;
        logic signed [47:0] xy;
        logic signed [47:0] yx;
    } prod6_t;

    logic              s1_valid_reg;
    logic              s1_valid_next;
    prod6_t            s1_prod_reg;
    prod6_t            s1_prod_next;
    qrto_pkg::quat_t   s1_q_reg;
    qrto_pkg::vec33_t  s1_base_reg;
    qrto_pkg::vec33_t  s1_base_next;

    logic              s2_valid_reg;
    qrto_pkg::quat_t   s2_q_reg;
    qrto_pkg::vec33_t  s2_base_reg;
    qrto_pkg::vec49_t  s2_tp_reg;
    qrto_pkg::vec49_t  s2_tp_next;

    always_comb
    begin
        s1_valid_next   = in_valid;
        s1_prod_next.yz = $signed(q.y) * $signed(offset.z);
        s1_prod_next.zy = $signed(q.z) * $signed(offset.y);
        s1_prod_next.zx = $signed(q.z) * $signed(offset.x);
        s1_prod_next.xz = $signed(q.x) * $signed(offset.z);
        s1_prod_next.xy = $signed(q.x) * $signed(offset.y);
        s1_prod_next.yx = $signed(q.y) * $signed(offset.x);
        s1_base_next.x  = $signed({offset.x[31], offset.x}) + $signed({pos.x[31], pos.x});
        s1_base_next.y  = $signed({offset.y[31], offset.y}) + $signed({pos.y[31], pos.y});
        s1_base_next.z  = $signed({offset.z[31], offset.z}) + $signed({pos.z[31], pos.z});
    end

    always_comb
    begin
        s2_tp_next.x = $signed({s1_prod_reg.yz[47], s1_prod_reg.yz})
                     - $signed({s1_prod_reg.zy[47], s1_prod_reg.zy});
        s2_tp_next.y = $signed({s1_prod_reg.zx[47], s1_prod_reg.zx})
                     - $signed({s1_prod_reg.xz[47], s1_prod_reg.xz});
        s2_tp_next.z = $signed({s1_prod_reg.xy[47], s1_prod_reg.xy})
                     - $signed({s1_prod_reg.yx[47], s1_prod_reg.yx});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_prod_reg <= s1_prod_next;
        s1_q_reg    <= q;
        s1_base_reg <= s1_base_next;
        s2_tp_reg   <= s2_tp_next;
        s2_q_reg    <= s1_q_reg;
        s2_base_reg <= s1_base_reg;
    end

    assign out_valid = s2_valid_reg;
    assign q_out     = s2_q_reg;
    assign base_out  = s2_base_reg;
    assign tp_out    = s2_tp_reg;

    // A valid result here always comes from a request at the input, carried through both stage registers.
    a_cross_valid_age: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $past(in_valid, 2))
        else $error("cross stage valid without matching input");

endmodule

`default_nettype wire

// File: hw/rtl/qrto_rotate.sv
// Two pipeline stages: w*t and q x t products, then exact accumulation with the base.
`default_nettype none

module qrto_rotate (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    input  wire qrto_pkg::quat_t  q,
    input  wire qrto_pkg::vec33_t base,
    input  wire qrto_pkg::vec49_t tp,
    output logic                 out_valid,
    output qrto_pkg::acc_t       acc
);

    // Per component: a = w*tp_i, b = q_j*tp_k, c = q_k*tp_j, units of 2^-46.
    typedef struct packed {
        logic signed [64:0] a;
        logic signed [64:0] b;
        logic signed [64:0] c;
    } trio_t;

    logic              s1_valid_reg;
    trio_t             s1_x_reg;
    trio_t             s1_y_reg;
    trio_t             s1_z_reg;
    trio_t             s1_x_next;
    trio_t             s1_y_next;
    trio_t             s1_z_next;
    qrto_pkg::vec33_t  s1_base_reg;

    logic              s2_valid_reg;
    qrto_pkg::acc_t    s2_acc_reg;
    qrto_pkg::acc_t    s2_acc_next;

    // Floor by four of a product, sign extended to the accumulator width.
    function automatic logic signed [65:0] floor4(input logic signed [64:0] p);
        floor4 = $signed({{3{p[64]}}, p[64:2]});
    endfunction

    // Base in units of 2^-43 with the half-LSB rounding bias of the final Q16.16 step.
    function automatic logic signed [65:0] base_term(input logic signed [32:0] b);
        base_term = $signed({{6{b[32]}}, b, 1'b1, 26'd0});
    endfunction

    always_comb
    begin
        s1_x_next.a = $signed(q.w) * $signed(tp.x);
        s1_x_next.b = $signed(q.y) * $signed(tp.z);
        s1_x_next.c = $signed(q.z) * $signed(tp.y);
        s1_y_next.a = $signed(q.w) * $signed(tp.y);
        s1_y_next.b = $signed(q.z) * $signed(tp.x);
        s1_y_next.c = $signed(q.x) * $signed(tp.z);
        s1_z_next.a = $signed(q.w) * $signed(tp.z);
        s1_z_next.b = $signed(q.x) * $signed(tp.y);
        s1_z_next.c = $signed(q.y) * $signed(tp.x);
    end

    always_comb
    begin
        s2_acc_next.x = floor4(s1_x_reg.a) + floor4(s1_x_reg.b) - floor4(s1_x_reg.c)
                      + base_term(s1_base_reg.x);
        s2_acc_next.y = floor4(s1_y_reg.a) + floor4(s1_y_reg.b) - floor4(s1_y_reg.c)
                      + base_term(s1_base_reg.y);
        s2_acc_next.z = floor4(s1_z_reg.a) + floor4(s1_z_reg.b) - floor4(s1_z_reg.c)
                      + base_term(s1_base_reg.z);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_x_reg    <= s1_x_next;
        s1_y_reg    <= s1_y_next;
        s1_z_reg    <= s1_z_next;
        s1_base_reg <= base;
        s2_acc_reg  <= s2_acc_next;
    end

    assign out_valid = s2_valid_reg;
    assign acc       = s2_acc_reg;

endmodule

`default_nettype wire

// File: hw/rtl/qrto_round_sat.sv
// Output stage: takes Q16.16 from the biased sums, saturates and flags overflow.
`default_nettype none

module qrto_round_sat (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    input  wire qrto_pkg::acc_t  acc,
    output logic                 done,
    output logic signed [31:0]   tool_x,
    output logic signed [31:0]   tool_y,
    output logic signed [31:0]   tool_z,
    output logic                 overflow
);

    logic               done_reg;
    logic signed [31:0] tool_x_reg;
    logic signed [31:0] tool_y_reg;
    logic signed [31:0] tool_z_reg;
    logic signed [31:0] tool_x_next;
    logic signed [31:0] tool_y_next;
    logic signed [31:0] tool_z_next;
    logic               ovf_x;
    logic               ovf_y;
    logic               ovf_z;
    logic               overflow_reg;
    logic               overflow_next;

    // The bias is already in the sum, so flooring by 27 bits is a plain bit select.
    function automatic logic signed [31:0] clamp(input logic signed [65:0] a);
        logic signed [38:0] r;
        r = a[65:27];
        if (r[38:31] == {8{r[38]}})
            clamp = r[31:0];
        else if (r[38])
            clamp = qrto_pkg::Q16_MIN;
        else
            clamp = qrto_pkg::Q16_MAX;
    endfunction

    function automatic logic fits(input logic signed [65:0] a);
        fits = (a[65:58] == {8{a[65]}});
    endfunction

    always_comb
    begin
        tool_x_next   = clamp(acc.x);
        tool_y_next   = clamp(acc.y);
        tool_z_next   = clamp(acc.z);
        ovf_x         = !fits(acc.x);
        ovf_y         = !fits(acc.y);
        ovf_z         = !fits(acc.z);
        overflow_next = ovf_x | ovf_y | ovf_z;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        tool_x_reg   <= tool_x_next;
        tool_y_reg   <= tool_y_next;
        tool_z_reg   <= tool_z_next;
        overflow_reg <= overflow_next;
    end

    assign done     = done_reg;
    assign tool_x   = tool_x_reg;
    assign tool_y   = tool_y_reg;
    assign tool_z   = tool_z_reg;
    assign overflow = overflow_reg;

    // A raised flag means at least one component sits at an end of the range.
    a_ovf_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        (done && overflow) |->
            (tool_x == qrto_pkg::Q16_MAX || tool_x == qrto_pkg::Q16_MIN ||
             tool_y == qrto_pkg::Q16_MAX || tool_y == qrto_pkg::Q16_MIN ||
             tool_z == qrto_pkg::Q16_MAX || tool_z == qrto_pkg::Q16_MIN))
        else $error("overflow flagged without a saturated component");

endmodule

`default_nettype wire

// File: hw/rtl/quaternion_rotate_tool_offset.sv
// Top level: config registers, input stage and the tool point pipeline.
//
//  Channel   Ports                                    Handshake
//  -------   -------------------------------------    ----------------------------
//  config    cfg_wr_en, cfg_index, cfg_data           write when cfg_wr_en is high
//  request   start, busy, pos_x/y/z, quat_x/y/z/w     taken when start && !busy
//  result    done, tool_x/y/z, overflow               one-cycle strobe on done
//
// One request is taken every cycle; busy stays low because nothing can back up.
// The result strobes on done once its request has passed the six register
// stages: input, q*v products, cross product, rotation products,
// accumulation, and rounding with saturation. Reset clears the valid bits
// and the offsets to zero; requests in flight at reset are dropped.
`default_nettype none

module quaternion_rotate_tool_offset (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_wr_en,
    input  wire logic [qrto_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [31:0]                         cfg_data,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic signed [31:0]                  pos_x,
    input  wire logic signed [31:0]                  pos_y,
    input  wire logic signed [31:0]                  pos_z,
    input  wire logic signed [15:0]                  quat_x,
    input  wire logic signed [15:0]                  quat_y,
    input  wire logic signed [15:0]                  quat_z,
    input  wire logic signed [15:0]                  quat_w,
    output logic                                     done,
    output logic signed [31:0]                       tool_x,
    output logic signed [31:0]                       tool_y,
    output logic signed [31:0]                       tool_z,
    output logic                                     overflow
);

    qrto_pkg::vec32_t  offset_reg;
    qrto_pkg::vec32_t  offset_next;

    logic              in_valid_reg;
    logic              accept;
    qrto_pkg::quat_t   quat_reg;
    qrto_pkg::vec32_t  pos_reg;

    logic              cr_valid;
    qrto_pkg::quat_t   cr_q;
    qrto_pkg::vec33_t  cr_base;
    qrto_pkg::vec49_t  cr_tp;

    logic              rot_valid;
    qrto_pkg::acc_t    rot_acc;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_comb
    begin
        offset_next = offset_reg;
        if (cfg_wr_en)
        begin
            unique case (qrto_pkg::reg_index_t'(cfg_index))
                qrto_pkg::REG_OFFSET_X: offset_next.x = cfg_data;
                qrto_pkg::REG_OFFSET_Y: offset_next.y = cfg_data;
                qrto_pkg::REG_OFFSET_Z: offset_next.z = cfg_data;
                default:                offset_next   = offset_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg   <= '0;
            in_valid_reg <= 1'b0;
        end
        else
        begin
            offset_reg   <= offset_next;
            in_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        quat_reg <= '{x: quat_x, y: quat_y, z: quat_z, w: quat_w};
        pos_reg  <= '{x: pos_x, y: pos_y, z: pos_z};
    end

    qrto_cross u_cross (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid_reg),
        .q         (quat_reg),
        .pos       (pos_reg),
        .offset    (offset_reg),
        .out_valid (cr_valid),
        .q_out     (cr_q),
        .base_out  (cr_base),
        .tp_out    (cr_tp)
    );

    qrto_rotate u_rotate (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cr_valid),
        .q         (cr_q),
        .base      (cr_base),
        .tp        (cr_tp),
        .out_valid (rot_valid),
        .acc       (rot_acc)
    );

    qrto_round_sat u_round_sat (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rot_valid),
        .acc       (rot_acc),
        .done      (done),
        .tool_x    (tool_x),
        .tool_y    (tool_y),
        .tool_z    (tool_z),
        .overflow  (overflow)
    );

    // Every request comes out of the pipeline as a strobe on done.
    a_request_delivered: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##(qrto_pkg::PIPE_LATENCY) done)
        else $error("request not delivered after pipeline latency");

    // No result appears without a request at the matching earlier edge.
    a_no_spurious_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, qrto_pkg::PIPE_LATENCY))
        else $error("result strobe without a matching request");

endmodule

`default_nettype wire
